@@ src/integer_to_base_n_ascii_macros.svh @@
// assertion helpers used by the checker file
`ifndef INTEGER_TO_BASE_N_ASCII_MACROS_SVH
`define INTEGER_TO_BASE_N_ASCII_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define I2B_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define I2B_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/i2b_pkg.sv @@
package i2b_pkg;

  localparam int VALUE_BITS_DEF = 32;
  localparam int CFG_W          = 6;
  localparam int DIGIT_W        = 6;
  localparam int CHAR_W         = 7;
  localparam int STATUS_W       = 2;

  localparam logic [CFG_W-1:0] RADIX_MIN   = 6'd2;
  localparam logic [CFG_W-1:0] RADIX_MAX   = 6'd36;
  localparam logic [CFG_W-1:0] RADIX_RESET = 6'd10;

  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_BAD_BASE = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NEGATIVE = 2'd2;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] CHAR_ALPHA = 7'h41;
  localparam logic [CHAR_W-1:0] CHAR_NONE  = 7'h00;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SPEC,
    ST_DIV,
    ST_RD,
    ST_LD
  } state_t;

  // digit value 0..35 to ascii
  function automatic logic [CHAR_W-1:0] digit_ascii(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] dx;
    dx = {1'b0, d};
    if (d < 6'd10) begin
      digit_ascii = CHAR_ZERO + dx;
    end else begin
      digit_ascii = CHAR_ALPHA + dx - 7'd10;
    end
  endfunction

endpackage

@@ src/i2b_ram.sv @@
module i2b_ram #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ src/integer_to_base_n_ascii.sv @@
// Converts one signed VALUE_BITS-bit integer per item into ASCII digits in
// the base held in the radix register (2 to 36; digits 0-9 then A-Z). Results
// come out one character each, most significant first, with out_last on the
// final one. Zero gives the single character '0'. A base outside 2..36 gives
// one result with status 1 (bad base, checked first); a negative value gives
// one result with status 2 (empty string); both carry digit_char 0 and last.
// Timing: each digit comes from a bit-serial restoring divide that retires one
// quotient bit per cycle. One item is converted at a time; a new item is taken
// as soon as the last result of the previous one sits in the output register.
// The radix register may only be written while the block is idle.
module integer_to_base_n_ascii #(
  parameter int VALUE_BITS = i2b_pkg::VALUE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration
  input  logic                          cfg_we,
  input  logic [i2b_pkg::CFG_W-1:0]     cfg_wdata,
  // input item
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [VALUE_BITS-1:0]  in_value,
  // result item
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [i2b_pkg::CHAR_W-1:0]    out_digit_char,
  output logic                          out_last,
  output logic [i2b_pkg::STATUS_W-1:0]  out_status
);

  import i2b_pkg::*;

  // magnitude width, quotient bit counter, digit counter, store address
  localparam int MAG_W  = VALUE_BITS - 1;
  localparam int BIT_W  = $clog2(MAG_W);
  localparam int CNT_W  = $clog2(VALUE_BITS + 1);
  localparam int ADDR_W = $clog2(VALUE_BITS);

  // control state
  state_t            state_r, state_nxt;
  logic [CFG_W-1:0]  radix_r;
  logic              out_valid_r, out_valid_nxt;

  // divide datapath
  logic [MAG_W-1:0]   q_r, q_nxt;
  logic [DIGIT_W-1:0] rem_r, rem_nxt;
  logic [BIT_W-1:0]   bit_r, bit_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;

  // pending special-case result
  logic [CHAR_W-1:0]   spec_char_r, spec_char_nxt;
  logic [STATUS_W-1:0] spec_status_r, spec_status_nxt;

  // output register payload
  logic [CHAR_W-1:0]   out_char_r, out_char_nxt;
  logic                out_last_r, out_last_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;

  // handshake and sequencing strobes
  logic in_fire;
  logic slot_free;
  logic out_load;
  logic ram_we;
  logic ram_re;

  // per-cycle divide step
  logic [DIGIT_W:0]   trial;
  logic [DIGIT_W:0]   trial_diff;
  logic               q_bit;
  logic [DIGIT_W-1:0] rem_step;
  logic [MAG_W-1:0]   q_step;
  logic               bit_last;
  logic [CNT_W-1:0]   cnt_inc;
  logic [CNT_W-1:0]   cnt_dec;
  logic               div_done;

  // item classification at accept
  logic bad_base;
  logic is_zero;
  logic is_neg;
  logic is_special;

  logic [DIGIT_W-1:0] ram_rdata;

  assign in_fire   = in_valid && in_ready;
  // output register can take a new result this cycle
  assign slot_free = !out_valid_r || out_ready;

  assign bad_base   = (radix_r < RADIX_MIN) || (radix_r > RADIX_MAX);
  assign is_zero    = (in_value == '0);
  assign is_neg     = in_value[VALUE_BITS-1];
  assign is_special = bad_base || is_zero || is_neg;

  // restoring divide: bring down the next dividend bit, subtract radix if it fits
  assign trial      = {rem_r, q_r[MAG_W-1]};
  assign trial_diff = trial - {1'b0, radix_r};
  assign q_bit      = (trial >= {1'b0, radix_r});
  assign rem_step   = q_bit ? trial_diff[DIGIT_W-1:0] : trial[DIGIT_W-1:0];
  assign q_step     = {q_r[MAG_W-2:0], q_bit};
  assign bit_last   = (bit_r == BIT_W'(MAG_W - 1));

  assign cnt_inc  = cnt_r + 1'b1;
  assign cnt_dec  = cnt_r - 1'b1;
  // stop once the quotient runs out or the store is full
  assign div_done = bit_last && ((q_step == '0) || (cnt_inc == CNT_W'(VALUE_BITS)));

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = is_special ? ST_SPEC : ST_DIV;
        end
      end
      ST_SPEC: begin
        if (slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_RD;
        end
      end
      ST_RD: begin
        state_nxt = ST_LD;
      end
      ST_LD: begin
        if (slot_free) begin
          state_nxt = (cnt_r == '0) ? ST_IDLE : ST_RD;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // fsm outputs
  always_comb begin
    in_ready = 1'b0;
    ram_we   = 1'b0;
    ram_re   = 1'b0;
    out_load = 1'b0;
    unique case (state_r)
      ST_IDLE: in_ready = 1'b1;
      ST_SPEC: out_load = slot_free;
      ST_DIV:  ram_we   = bit_last;
      ST_RD:   ram_re   = 1'b1;
      ST_LD:   out_load = slot_free;
      default: in_ready = 1'b0;
    endcase
  end

  // datapath next values
  always_comb begin
    q_nxt           = q_r;
    rem_nxt         = rem_r;
    bit_nxt         = bit_r;
    cnt_nxt         = cnt_r;
    spec_char_nxt   = spec_char_r;
    spec_status_nxt = spec_status_r;

    if (in_fire) begin
      q_nxt   = in_value[MAG_W-1:0];
      rem_nxt = '0;
      bit_nxt = '0;
      cnt_nxt = '0;
      // bad base wins over zero, zero over negative
      priority if (bad_base) begin
        spec_char_nxt   = CHAR_NONE;
        spec_status_nxt = STATUS_BAD_BASE;
      end else if (is_zero) begin
        spec_char_nxt   = CHAR_ZERO;
        spec_status_nxt = STATUS_OK;
      end else begin
        spec_char_nxt   = CHAR_NONE;
        spec_status_nxt = STATUS_NEGATIVE;
      end
    end else if (state_r == ST_DIV) begin
      q_nxt = q_step;
      if (bit_last) begin
        // remainder is the digit; quotient carries into the next digit
        rem_nxt = '0;
        bit_nxt = '0;
        cnt_nxt = cnt_inc;
      end else begin
        rem_nxt = rem_step;
        bit_nxt = BIT_W'(bit_r + 1'b1);
      end
    end else if (ram_re) begin
      cnt_nxt = cnt_dec;
    end
  end

  // output register: loads a result, clears when taken
  always_comb begin
    out_char_nxt   = out_char_r;
    out_last_nxt   = out_last_r;
    out_status_nxt = out_status_r;
    out_valid_nxt  = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
      if (state_r == ST_SPEC) begin
        out_char_nxt   = spec_char_r;
        out_last_nxt   = 1'b1;
        out_status_nxt = spec_status_r;
      end else begin
        out_char_nxt   = digit_ascii(ram_rdata);
        out_last_nxt   = (cnt_r == '0);
        out_status_nxt = STATUS_OK;
      end
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      radix_r     <= RADIX_RESET;
      out_valid_r <= 1'b0;
      q_r         <= '0;
      cnt_r       <= '0;
      bit_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      q_r         <= q_nxt;
      cnt_r       <= cnt_nxt;
      bit_r       <= bit_nxt;
      if (cfg_we) begin
        radix_r <= cfg_wdata;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    rem_r         <= rem_nxt;
    spec_char_r   <= spec_char_nxt;
    spec_status_r <= spec_status_nxt;
    out_char_r    <= out_char_nxt;
    out_last_r    <= out_last_nxt;
    out_status_r  <= out_status_nxt;
  end

  // digit store: remainders least significant first, read back in reverse
  i2b_ram #(
    .WIDTH (DIGIT_W),
    .DEPTH (VALUE_BITS)
  ) u_digit_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cnt_r[ADDR_W-1:0]),
    .wdata (rem_step),
    .re    (ram_re),
    .raddr (cnt_dec[ADDR_W-1:0]),
    .rdata (ram_rdata)
  );

  assign out_valid      = out_valid_r;
  assign out_digit_char = out_char_r;
  assign out_last       = out_last_r;
  assign out_status     = out_status_r;

endmodule

@@ src/i2b_checker.sv @@
`include "integer_to_base_n_ascii_macros.svh"

module i2b_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [i2b_pkg::CHAR_W-1:0]   out_digit_char,
  input logic                         out_last,
  input logic [i2b_pkg::STATUS_W-1:0] out_status
);

  import i2b_pkg::*;

  // stalled result holds
  `I2B_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_digit_char) && $stable(out_last) && $stable(out_status), "stalled result changed")

  // error results are single, empty and last
  `I2B_ASSERT_NOW(a_err_shape, out_valid && (out_status != STATUS_OK), out_last && (out_digit_char == CHAR_NONE), "error result not a lone empty last item")

  // good results carry a real digit character
  `I2B_ASSERT_NOW(a_digit_char, out_valid && (out_status == STATUS_OK), ((out_digit_char >= 7'h30) && (out_digit_char <= 7'h39)) || ((out_digit_char >= 7'h41) && (out_digit_char <= 7'h5A)), "digit character out of range")

  // only defined status codes
  `I2B_ASSERT_NOW(a_status_code, out_valid, (out_status == STATUS_OK) || (out_status == STATUS_BAD_BASE) || (out_status == STATUS_NEGATIVE), "undefined status code")

endmodule

bind integer_to_base_n_ascii i2b_checker u_i2b_checker (.*);
